FILE: rtl/kdlp_pkg.sv
// kdlp_pkg: shared types and constants for the key debounce block.
// No dependencies; imported by every other file of the block but kdlp_intf.
`default_nettype none

package kdlp_pkg;

  // Event kinds as they leave the block
  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_LONG    = 2'd2,
    KIND_REPEAT  = 2'd3
  } kdlp_kind_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FILTER_TIME  = 3'd0,
    CFG_LONG_TIME    = 3'd1,
    CFG_REPEAT_SPEED = 3'd2,
    CFG_CODE_DOWN    = 3'd3,
    CFG_CODE_UP      = 3'd4,
    CFG_CODE_LONG    = 3'd5
  } kdlp_cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [7:0]  FILTER_TIME_RST  = 8'd2;
  localparam logic [15:0] LONG_TIME_RST    = 16'd150;
  localparam logic [7:0]  REPEAT_SPEED_RST = 8'd0;
  localparam logic [7:0]  CODE_DOWN_RST    = 8'd1;
  localparam logic [7:0]  CODE_UP_RST      = 8'd2;
  localparam logic [7:0]  CODE_LONG_RST    = 8'd3;

  // Filter counter starts at half the reset filter time
  localparam logic [8:0]  FILTER_COUNT_RST = {1'b0, FILTER_TIME_RST >> 1};

  typedef struct packed {
    logic [7:0]  filter_time;
    logic [15:0] long_time;
    logic [7:0]  repeat_speed;
    logic [7:0]  code_down;
    logic [7:0]  code_up;
    logic [7:0]  code_long;
  } kdlp_cfg_t;

  // One event record
  typedef struct packed {
    logic [7:0] code;
    kdlp_kind_e kind;
  } kdlp_event_t;

  // Events caused by one tick: ev0 always, ev1 when two is set
  typedef struct packed {
    logic        two;
    kdlp_event_t ev0;
    kdlp_event_t ev1;
  } kdlp_bundle_t;

endpackage

`default_nettype wire

FILE: rtl/kdlp_intf.sv
// kdlp_in_if / kdlp_out_if: valid/ready channels of the key debounce block.
// Depends on kdlp_pkg for nothing but is compiled after it.
`default_nettype none

interface kdlp_in_if;
  logic valid;
  logic ready;
  logic key_pressed;

  modport source (output valid, output key_pressed, input ready);
  modport sink   (input valid, input key_pressed, output ready);
endinterface

interface kdlp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;
  logic [1:0] event_kind;
  logic       last_event;

  modport source (output valid, output key_code, output event_kind, output last_event,
                  input ready);
  modport sink   (input valid, input key_code, input event_kind, input last_event,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/key_debounce_long_press_repeat.sv
// key_debounce_long_press_repeat: top level, config registers, front, queue, back.
// Depends on kdlp_pkg, kdlp_intf, kdlp_front, kdlp_queue, kdlp_back.
//
//   channel  dir  beat payload                          handshake
//   in_ch    in   key_pressed                           valid/ready
//   out_ch   out  key_code, event_kind, last_event      valid/ready
//   cfg      in   cfg_idx_i, cfg_data_i                 cfg_we_i, no wait
//
// One tick is accepted per cycle while the queue has room; the tick's state update
// is done by the counter logic in the front. Events reach out_ch through the queue
// and then the output register in the back, one per cycle while out_ch is ready.
// Output stalls back up through the DEPTH-entry queue before in_ch drops ready.
// Reset clears counters, queue and output register at once; no clearing pass.
`default_nettype none

module key_debounce_long_press_repeat
  import kdlp_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  kdlp_in_if.sink                in_ch,
  kdlp_out_if.source             out_ch,
  input  wire                    cfg_we_i,
  input  wire [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [CFG_DATA_W-1:0]   cfg_data_i
);

  kdlp_cfg_t    cfg_q;
  logic         q_full, q_valid, push, pop;
  kdlp_bundle_t push_data, pop_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_time  <= FILTER_TIME_RST;
      cfg_q.long_time    <= LONG_TIME_RST;
      cfg_q.repeat_speed <= REPEAT_SPEED_RST;
      cfg_q.code_down    <= CODE_DOWN_RST;
      cfg_q.code_up      <= CODE_UP_RST;
      cfg_q.code_long    <= CODE_LONG_RST;
    end else if (cfg_we_i) begin
      case (kdlp_cfg_idx_e'(cfg_idx_i))
        CFG_FILTER_TIME:  cfg_q.filter_time  <= cfg_data_i[7:0];
        CFG_LONG_TIME:    cfg_q.long_time    <= cfg_data_i;
        CFG_REPEAT_SPEED: cfg_q.repeat_speed <= cfg_data_i[7:0];
        CFG_CODE_DOWN:    cfg_q.code_down    <= cfg_data_i[7:0];
        CFG_CODE_UP:      cfg_q.code_up      <= cfg_data_i[7:0];
        CFG_CODE_LONG:    cfg_q.code_long    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  kdlp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_ch.valid),
    .in_pressed_i (in_ch.key_pressed),
    .in_ready_o   (in_ch.ready),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  kdlp_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  kdlp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_code_o  (out_ch.key_code),
    .out_kind_o  (out_ch.event_kind),
    .out_last_o  (out_ch.last_event)
  );

endmodule

`default_nettype wire

FILE: rtl/kdlp_front.sv
// kdlp_front: debounce filter, hold and repeat counters; classifies each tick.
// Depends on kdlp_pkg; pushes event bundles into kdlp_queue.
`default_nettype none

module kdlp_front
  import kdlp_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  kdlp_cfg_t    cfg_i,
  input  wire          in_valid_i,
  input  wire          in_pressed_i,
  output logic         in_ready_o,
  input  wire          q_full_i,
  output logic         push_o,
  output kdlp_bundle_t push_data_o
);

  logic [8:0]  filter_count_q, filter_count_d;
  logic        deb_q, deb_d;
  logic [15:0] hold_q, hold_d;
  logic [7:0]  rep_q, rep_d;

  logic        accept;
  logic        emit_press, emit_release, emit_long, emit_rep;
  logic [8:0]  top;
  logic [8:0]  ft9;
  logic [15:0] hold_inc;
  logic [7:0]  rep_inc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign top        = {cfg_i.filter_time, 1'b0};
  assign ft9        = {1'b0, cfg_i.filter_time};
  assign hold_inc   = hold_q + 16'd1;
  assign rep_inc    = rep_q + 8'd1;

  // next state and event flags for the current sample
  always_comb begin
    filter_count_d = filter_count_q;
    deb_d          = deb_q;
    hold_d         = hold_q;
    rep_d          = rep_q;
    emit_press     = 1'b0;
    emit_release   = 1'b0;
    emit_long      = 1'b0;
    emit_rep       = 1'b0;
    if (in_pressed_i) begin
      if (filter_count_q < ft9) begin
        filter_count_d = ft9;
      end else if (filter_count_q < top) begin
        filter_count_d = filter_count_q + 9'd1;
      end else begin
        if (!deb_q) begin
          deb_d      = 1'b1;
          emit_press = (cfg_i.code_down != 8'd0);
        end
        if (cfg_i.long_time != 16'd0) begin
          if (hold_q < cfg_i.long_time) begin
            hold_d    = hold_inc;
            emit_long = (hold_inc == cfg_i.long_time);
          end else if (cfg_i.repeat_speed != 8'd0) begin
            rep_d = rep_inc;
            if (rep_inc >= cfg_i.repeat_speed) begin
              rep_d    = 8'd0;
              emit_rep = 1'b1;
            end
          end
        end
      end
    end else begin
      if (filter_count_q > ft9) begin
        filter_count_d = ft9;
      end else if (filter_count_q != 9'd0) begin
        filter_count_d = filter_count_q - 9'd1;
      end else if (deb_q) begin
        deb_d        = 1'b0;
        emit_release = (cfg_i.code_up != 8'd0);
      end
      hold_d = 16'd0;
      rep_d  = 8'd0;
    end
  end

  // pack the flags into a bundle, press always first
  always_comb begin
    push_data_o.two      = 1'b0;
    push_data_o.ev0.code = cfg_i.code_down;
    push_data_o.ev0.kind = KIND_PRESS;
    push_data_o.ev1.code = cfg_i.code_long;
    push_data_o.ev1.kind = KIND_LONG;
    if (emit_press) begin
      push_data_o.two = emit_long || emit_rep;
      if (emit_rep) begin
        push_data_o.ev1.code = cfg_i.code_down;
        push_data_o.ev1.kind = KIND_REPEAT;
      end
    end else if (emit_release) begin
      push_data_o.ev0.code = cfg_i.code_up;
      push_data_o.ev0.kind = KIND_RELEASE;
    end else if (emit_long) begin
      push_data_o.ev0.code = cfg_i.code_long;
      push_data_o.ev0.kind = KIND_LONG;
    end else begin
      push_data_o.ev0.code = cfg_i.code_down;
      push_data_o.ev0.kind = KIND_REPEAT;
    end
  end

  assign push_o = accept && (emit_press || emit_release || emit_long || emit_rep);

  // tick state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_count_q <= FILTER_COUNT_RST;
      deb_q          <= 1'b0;
      hold_q         <= 16'd0;
      rep_q          <= 8'd0;
    end else if (accept) begin
      filter_count_q <= filter_count_d;
      deb_q          <= deb_d;
      hold_q         <= hold_d;
      rep_q          <= rep_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/kdlp_queue.sv
// kdlp_queue: small FIFO of event bundles between front and back.
// Depends on kdlp_pkg for the bundle type.
`default_nettype none

module kdlp_queue
  import kdlp_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          push_i,
  input  kdlp_bundle_t push_data_i,
  output logic         full_o,
  input  wire          pop_i,
  output logic         valid_o,
  output kdlp_bundle_t pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  kdlp_bundle_t  mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o     = (count_q == FULL_CNT);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  // a push is never offered to a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

  // fill count stays in range
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT) else $error("queue count out of range");

  // fill count advances on a push without a pop
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("queue count did not advance");

endmodule

`default_nettype wire

FILE: rtl/kdlp_back.sv
// kdlp_back: unpacks event bundles into single output beats held in a register.
// Depends on kdlp_pkg; pops bundles from kdlp_queue.
`default_nettype none

module kdlp_back
  import kdlp_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          q_valid_i,
  input  kdlp_bundle_t q_data_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output logic [7:0]   out_code_o,
  output logic [1:0]   out_kind_o,
  output logic         out_last_o
);

  kdlp_bundle_t cur_q;
  logic         valid_q;
  logic         sel_q;
  logic         last;
  logic         taken;
  kdlp_event_t  ev;

  assign ev    = sel_q ? cur_q.ev1 : cur_q.ev0;
  assign last  = !cur_q.two || sel_q;
  assign taken = valid_q && out_ready_i;
  assign pop_o = q_valid_i && (!valid_q || (taken && last));

  assign out_valid_o = valid_q;
  assign out_code_o  = ev.code;
  assign out_kind_o  = ev.kind;
  assign out_last_o  = last;

  // output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      sel_q   <= 1'b0;
    end else if (taken) begin
      if (last) begin
        valid_q <= 1'b0;
        sel_q   <= 1'b0;
      end else begin
        sel_q <= 1'b1;
      end
    end
  end

  // bundle payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
    end
  end

  // second event of a tick follows right after the first
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (taken && !last) |=> (valid_q && sel_q)) else $error("second event lost");

  // second event is always marked last
  a_second_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && sel_q) |-> last) else $error("second event not last");

  // a held bundle is not replaced before its last beat goes out
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !(taken && last)) |-> !pop_o) else $error("bundle overwritten");

endmodule

`default_nettype wire
